### rtl/core/patb_pkg.sv
// ----------------------------------------------------------------------------
// patb_pkg
// Shared constants for the per-account token bucket: field widths, the
// fixed-point token format, table geometry, register indexes and codes.
// ----------------------------------------------------------------------------
package patb_pkg;

  // Table geometry.
  localparam int Accounts = 1024;
  localparam int AddrW    = (Accounts > 1) ? $clog2(Accounts) : 1;

  // Field widths.
  localparam int IdxW  = 10;
  localparam int TimeW = 48;
  localparam int CapW  = 8;
  localparam int RateW = 32;

  // Tokens are unsigned fixed point: CapW integer bits, FracBits fraction bits.
  localparam int FracBits = 32;
  localparam int TokW     = CapW + FracBits;

  // Width used to range-check an account index against the table depth.
  localparam int ExtW = ((AddrW > IdxW) ? AddrW : IdxW) + 1;

  // Refill product: the elapsed time is split into a low and a high part.
  localparam int ElLoW = 32;
  localparam int ElHiW = TimeW - ElLoW;
  localparam int ProdW = TimeW + RateW;

  // One table entry: seen flag, token count, time of the last refill.
  localparam int EntryW = 1 + TokW + TimeW;

  // Configuration port.
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgBurstCap = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgRefill   = CfgIdxW'(1);

  // Register reset values.
  localparam logic [CapW-1:0]  BurstCapRst = CapW'(10);
  localparam logic [RateW-1:0] RefillRst   = RateW'(497);

  // Request codes.
  localparam logic ReqTake = 1'b0;
  localparam logic ReqGive = 1'b1;

  // One whole token in fixed point.
  localparam logic [TokW-1:0] OneToken = TokW'(1) << FracBits;

  // Stored table entry.
  typedef struct packed {
    logic             seen;
    logic [TokW-1:0]  tokens;
    logic [TimeW-1:0] last_time;
  } entry_t;

endpackage

### rtl/core/patb_ram.sv
// ----------------------------------------------------------------------------
// patb_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read output.
// ----------------------------------------------------------------------------
module patb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/per_account_token_bucket_unit.sv
// ----------------------------------------------------------------------------
// per_account_token_bucket_unit
// Per-account token bucket rate limiter. Bucket state lives in one table
// memory that each request reads, updates and writes back.
// ----------------------------------------------------------------------------
// Flow: an accepted item passes the read, multiply, sum, update and grant
// states, then shows its result with done_o high for one cycle; the receiver
// cannot stall it. No new item is taken until the current one is through the
// table read, split refill multiply, capped sum and write-back of the entry.
// Reset: registers take their reset values, then a clearing pass over every
// entry marks each bucket unseen while busy and register writes are held off.
// ----------------------------------------------------------------------------
module per_account_token_bucket_unit
  import patb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Request channel.
  input  logic                start,
  output logic                busy,
  input  logic                req_type_i,
  input  logic [IdxW-1:0]     account_index_i,
  input  logic [TimeW-1:0]    now_time_i,
  // Result channel.
  output logic                done_o,
  output logic                granted_o,
  output logic [CapW-1:0]     tokens_whole_o,
  // Configuration write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [RateW-1:0]    cfg_data_i
);

  // Sequencer states.
  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StSum   = 3'd4;
  localparam logic [2:0] StUpd   = 3'd5;
  localparam logic [2:0] StGrant = 3'd6;

  // Widths of the two partial products.
  localparam int LoProdW = ElLoW + RateW;
  localparam int HiProdW = ElHiW + RateW;

  logic [2:0]       state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q;

  logic [CapW-1:0]  burst_cap_q;
  logic [RateW-1:0] refill_q;

  // Request registers.
  logic             req_type_q;
  logic             in_range_q;
  logic [AddrW-1:0] addr_q;
  logic [TimeW-1:0] now_q;
  entry_t           entry_q;
  logic [TimeW-1:0] elapsed_q;
  logic [LoProdW-1:0] prod_lo_q;
  logic [HiProdW-1:0] prod_hi_q;
  logic [TokW-1:0]  refill_amt_q;
  logic [TokW-1:0]  tok_q;

  // Result registers.
  logic             done_q;
  logic             granted_q;
  logic [CapW-1:0]  whole_q;

  // Memory ports.
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  entry_t           ram_rdata;

  logic             accept;
  logic [ExtW-1:0]  acct_ext;
  logic [TokW-1:0]  cap_fixed;
  logic [ProdW-1:0] prod_full;
  logic [TokW:0]    sum_tok;
  logic [TokW-1:0]  addend;
  logic [TokW-1:0]  tok_final;
  logic             grant_now;

  assign busy        = (state_q != StIdle);
  assign accept      = start && !busy;
  // Register writes only land while no item is in flight.
  assign cfg_ready_o = !busy;

  assign acct_ext  = ExtW'(account_index_i);
  assign cap_fixed = {burst_cap_q, {FracBits{1'b0}}};

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_cap_q <= BurstCapRst;
      refill_q    <= RefillRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgBurstCap: burst_cap_q <= cfg_data_i[CapW-1:0];
        CfgRefill:   refill_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (clr_cnt_q == AddrW'(Accounts - 1)) state_d = StIdle;
      StIdle:  if (accept) state_d = StRead;
      StRead:  state_d = StMul;
      StMul:   state_d = StSum;
      StSum:   state_d = StUpd;
      StUpd:   state_d = StGrant;
      StGrant: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StGrant);
      if (state_q == StClear) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
    end
  end

  // Latch the request when it is accepted.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_type_q <= req_type_i;
      in_range_q <= acct_ext < ExtW'(Accounts);
      addr_q     <= acct_ext[AddrW-1:0];
      now_q      <= now_time_i;
    end
  end

  // Table read data arrives; work out the elapsed time, zero if time ran back.
  always_ff @(posedge clk_i) begin
    if (state_q == StRead) begin
      entry_q   <= ram_rdata;
      elapsed_q <= (now_q >= ram_rdata.last_time) ? now_q - ram_rdata.last_time : '0;
    end
  end

  // Refill product, split into two partial products.
  always_ff @(posedge clk_i) begin
    if (state_q == StMul) begin
      prod_lo_q <= LoProdW'(elapsed_q[ElLoW-1:0]) * LoProdW'(refill_q);
      prod_hi_q <= HiProdW'(elapsed_q[TimeW-1:ElLoW]) * HiProdW'(refill_q);
    end
  end

  // Combine the partial products and saturate at the cap.
  assign prod_full = ProdW'(prod_lo_q) + {prod_hi_q, {ElLoW{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (state_q == StSum) begin
      refill_amt_q <= (prod_full > ProdW'(cap_fixed)) ? cap_fixed : prod_full[TokW-1:0];
    end
  end

  // Add the refill (take) or one token (give back), capped at the burst size; an unseen bucket starts full.
  assign addend  = (req_type_q == ReqTake) ? refill_amt_q : OneToken;
  assign sum_tok = {1'b0, entry_q.tokens} + {1'b0, addend};

  always_ff @(posedge clk_i) begin
    if (state_q == StUpd) begin
      if (!entry_q.seen) begin
        tok_q <= cap_fixed;
      end else if (sum_tok > {1'b0, cap_fixed}) begin
        tok_q <= cap_fixed;
      end else begin
        tok_q <= sum_tok[TokW-1:0];
      end
    end
  end

  // Grant and deduct one token on a take when a whole token is held.
  assign grant_now = (req_type_q == ReqTake) && (tok_q >= OneToken);
  assign tok_final = grant_now ? tok_q - OneToken : tok_q;

  always_ff @(posedge clk_i) begin
    if (state_q == StGrant) begin
      if (in_range_q && ((req_type_q == ReqTake) || entry_q.seen)) begin
        granted_q <= grant_now;
        whole_q   <= tok_final[TokW-1:FracBits];
      end else begin
        granted_q <= 1'b0;
        whole_q   <= '0;
      end
    end
  end

  // Memory access: clearing pass after reset, otherwise the write-back.
  always_comb begin
    ram_wdata.seen      = 1'b1;
    ram_wdata.tokens    = tok_final;
    ram_wdata.last_time = (req_type_q == ReqTake) ? now_q : entry_q.last_time;
    ram_waddr           = addr_q;
    ram_we              = (state_q == StGrant) && in_range_q &&
                          ((req_type_q == ReqTake) || entry_q.seen);
    if (state_q == StClear) begin
      ram_wdata.seen = 1'b0;
      ram_waddr      = clr_cnt_q;
      ram_we         = 1'b1;
    end
  end

  assign ram_re = accept;

  patb_ram #(
    .Width (EntryW),
    .Depth (Accounts)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (acct_ext[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign done_o         = done_q;
  assign granted_o      = done_q && granted_q;
  assign tokens_whole_o = done_q ? whole_q : '0;

  // A result follows the write-back step and nothing else.
  a_done_after_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == StGrant))
    else $error("result strobe without a finished update");

  // The block is free again in the cycle that shows a result.
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("busy while a result is shown");

  // A grant is only ever reported with a result.
  a_grant_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    granted_o |-> done_o)
    else $error("grant without result strobe");

  // An accepted item always gets its result.
  a_item_completes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_o)
    else $error("accepted item did not complete");

endmodule
